FILE: design/iocrob_pkg.sv
// package for the in-order completion reorder buffer
// holds the command codes and the word types of both channels; no dependencies

package iocrob_pkg;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_FORCE  = 2'd3;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    localparam int THR_W = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] seq_id;
        logic [31:0] record;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] out_seq;
        logic [31:0] out_record;
        logic        last;
    } out_word_t;

endpackage

FILE: design/iocrob_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module iocrob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/in_order_completion_reorder_buffer.sv
// in-order completion reorder buffer: releases finished records in sequence order
// depends on iocrob_pkg and iocrob_ram
// a rejection shows on the output the cycle after its word is taken; a finish, flush or
//   force scans the finished run one slot a cycle; if the run reaches the threshold, or on
//   force, it reads the ram, then releases one record a cycle while the output is not stalled
// input: a new word is taken only in idle with the output free, so finish, flush and force
//   words hold off the next word until the scan and any release of the run are done
// reset: rst_n clears head, started and finished bits at once; no clearing pass

module in_order_completion_reorder_buffer #(
    parameter int WINDOW = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [iocrob_pkg::THR_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  iocrob_pkg::in_word_t        in_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output iocrob_pkg::out_word_t       out_word
);

    import iocrob_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [31:0]       head_seq_reg, head_seq_next;
    logic [IW-1:0]     head_ptr_reg, head_ptr_next;
    logic [WINDOW-1:0] started_reg, started_next;
    logic [WINDOW-1:0] finished_reg, finished_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     scan_ptr_reg, scan_ptr_next;
    logic              force_reg, force_next;
    logic [THR_W-1:0]  thr_reg;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;
    logic              out_load;

    logic              in_take;
    logic              out_free;
    logic [31:0]       slot_off;
    logic              in_window;
    logic [IW:0]       phys_sum;
    logic [IW-1:0]     phys;
    logic [IW-1:0]     head_ptr_inc;
    logic [IW-1:0]     scan_ptr_inc;
    logic              run_go;

    logic              ram_we;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !(state_reg == ST_IDLE && out_free);
    assign in_take  = in_valid && !in_stall;

    // slot offset from the head, then its place in the circular store
    assign slot_off  = in_word.seq_id - head_seq_reg;
    assign in_window = slot_off < 32'(WINDOW);
    assign phys_sum  = {1'b0, head_ptr_reg} + {1'b0, slot_off[IW-1:0]};
    assign phys      = (phys_sum >= (IW+1)'(WINDOW)) ? IW'(phys_sum - (IW+1)'(WINDOW))
                                                      : phys_sum[IW-1:0];

    assign head_ptr_inc = (head_ptr_reg == IW'(WINDOW - 1)) ? '0 : head_ptr_reg + 1'b1;
    assign scan_ptr_inc = (scan_ptr_reg == IW'(WINDOW - 1)) ? '0 : scan_ptr_reg + 1'b1;

    assign run_go = (count_reg != '0) &&
                    (force_reg || (32'(count_reg) >= 32'(thr_reg)));

    assign ram_we = in_take && in_word.command == CMD_FINISH && in_window &&
                    started_reg[phys] && !finished_reg[phys];

    always_comb
    begin
        state_next     = state_reg;
        head_seq_next  = head_seq_reg;
        head_ptr_next  = head_ptr_reg;
        started_next   = started_reg;
        finished_next  = finished_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        force_next     = force_reg;
        out_load       = 1'b0;
        out_word_next  = out_word_reg;
        ram_re         = 1'b0;
        ram_raddr      = head_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (in_word.command) inside
                        CMD_BEGIN, CMD_FINISH:
                        begin
                            if (!in_window || (in_word.command == CMD_FINISH &&
                                (!started_reg[phys] || finished_reg[phys])))
                            begin
                                out_load      = 1'b1;
                                out_word_next = '{kind: KIND_REJECT,
                                                  out_seq: in_word.seq_id,
                                                  out_record: 32'd0,
                                                  last: 1'b1};
                            end
                            else if (in_word.command == CMD_BEGIN)
                            begin
                                started_next[phys]  = 1'b1;
                                finished_next[phys] = 1'b0;
                            end
                            else
                            begin
                                finished_next[phys] = 1'b1;
                                force_next    = 1'b0;
                                count_next    = '0;
                                scan_ptr_next = head_ptr_reg;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            force_next    = (in_word.command == CMD_FORCE);
                            count_next    = '0;
                            scan_ptr_next = head_ptr_reg;
                            state_next    = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (count_reg != CW'(WINDOW) && finished_reg[scan_ptr_reg])
                begin
                    count_next    = count_reg + 1'b1;
                    scan_ptr_next = scan_ptr_inc;
                end
                else if (run_go)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = head_ptr_reg;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_word_next = '{kind: KIND_RELEASE,
                                      out_seq: head_seq_reg,
                                      out_record: ram_rdata,
                                      last: (count_reg == CW'(1))};
                    started_next[head_ptr_reg]  = 1'b0;
                    finished_next[head_ptr_reg] = 1'b0;
                    head_seq_next = head_seq_reg + 32'd1;
                    head_ptr_next = head_ptr_inc;
                    count_next    = count_reg - 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next record while this word goes out
                        ram_re    = 1'b1;
                        ram_raddr = head_ptr_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_seq_reg  <= '0;
            head_ptr_reg  <= '0;
            started_reg   <= '0;
            finished_reg  <= '0;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            force_reg     <= 1'b0;
            thr_reg       <= THR_W'(8);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_seq_reg  <= head_seq_next;
            head_ptr_reg  <= head_ptr_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            count_reg     <= count_next;
            scan_ptr_reg  <= scan_ptr_next;
            force_reg     <= force_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    iocrob_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW)
    ) u_record_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (phys),
        .wdata (in_word.record),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a released slot must be finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && out_free) |-> finished_reg[head_ptr_reg])
    else $error("releasing a slot that is not finished");

    // the head moves only while records are being released
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WAIT) |=> (head_seq_reg == $past(head_seq_reg)))
    else $error("head moved outside a release");

    // a release burst always has records left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_WAIT) |-> (count_reg != '0))
    else $error("release with empty count");

    // the scan never counts past the window
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW))
    else $error("run count beyond window");

endmodule
